### rtl/shot_heat_budget_limiter_defines.svh
// Assertion macros shared by the shot heat budget limiter RTL.
// Each macro expects signals named clk and rst_n in the calling scope.
`ifndef SHOT_HEAT_BUDGET_LIMITER_DEFINES_SVH
`define SHOT_HEAT_BUDGET_LIMITER_DEFINES_SVH
`ifndef SYNTHESIS
`define SHBL_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define SHBL_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SHBL_ASSERT_IMP(lbl, ante, cons, msg)
`define SHBL_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

### rtl/shbl_pkg.sv
package shbl_pkg;

    localparam int HEAT_WIDTH_DEF = 24;
    localparam int RATE_WIDTH_DEF = 16;

    // Field widths
    localparam int CUR_W   = 16;
    localparam int SPD_W   = 15;
    localparam int DES_W   = 17;
    localparam int CAP_W   = 16;
    localparam int HEAT_W  = 24;
    localparam int CPT_W   = 16;
    localparam int QT_W    = 12;
    localparam int RATE_W  = 16;
    localparam int PHASE_W = 2;

    localparam int S_DATA_W  = 80;
    localparam int M_DATA_W  = 48;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 24;

    // Safe-rate arithmetic
    localparam int NUM_W  = 28;            // 10*(heat_max-heat)+cooling_rate
    localparam int DVD_W  = NUM_W + 8;     // numerator scaled to Q8 rate
    localparam int DEN_W  = HEAT_W;        // heat_per_shot
    localparam int PROD_W = HEAT_W + RATE_W;

    localparam logic [QT_W-1:0] COUNT_MAX = '1;
    localparam int NEAR_CEIL = 65;

    localparam logic [HEAT_W-1:0] HEAT_MAX_RST      = 24'd15073280;
    localparam logic [HEAT_W-1:0] HEAT_PER_SHOT_RST = 24'd655360;
    localparam logic [HEAT_W-1:0] COOLING_RATE_RST  = 24'd917504;
    localparam logic [CPT_W-1:0]  COOL_PER_TICK_RST = 16'd918;
    localparam logic [CUR_W-1:0]  CUR_THRESH_RST    = 16'd1400;
    localparam logic [QT_W-1:0]   QUIET_TICKS_RST   = 12'd20;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HEAT_MAX      = 3'd0,
        CFG_HEAT_PER_SHOT = 3'd1,
        CFG_COOLING_RATE  = 3'd2,
        CFG_COOL_PER_TICK = 3'd3,
        CFG_CUR_THRESH    = 3'd4,
        CFG_QUIET_TICKS   = 3'd5
    } cfg_idx_t;

    typedef enum logic [PHASE_W-1:0] {
        PH_STOPPED  = 2'd0,
        PH_PRECHECK = 2'd1,
        PH_SUSPECT  = 2'd2,
        PH_CONFIRM  = 2'd3
    } phase_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPD,
        ST_COOL,
        ST_NEAR,
        ST_CHK,
        ST_DIV,
        ST_FIN,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic [HEAT_W-1:0]       heat_max;
        logic [HEAT_W-1:0]       heat_per_shot;
        logic [HEAT_W-1:0]       cooling_rate;
        logic [CPT_W-1:0]        cool_per_tick;
        logic signed [CUR_W-1:0] current_threshold;
        logic [QT_W-1:0]         quiet_ticks;
    } cfg_t;

    typedef struct packed {
        logic load_in;
        logic upd;
        logic cool;
        logic near;
        logic chk;
        logic div_start;
        logic fin;
        logic load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic need_div;
        logic div_done;
    } dp_stat_t;

endpackage

### rtl/shot_heat_budget_limiter.sv
// Channel   Dir  Handshake            Payload
// s_*       in   s_tvalid/s_tready    s_tdata: one tick of wheel and rate readings
// m_*       out  m_tvalid/m_tready    m_tdata: heat level, allowed rate, shot, phase
// cfg_*     in   cfg_valid/cfg_ready  cfg_index, cfg_data: register write
//
// Path: the divider is skipped when the requested rate is sustainable or heat is near the
//   ceiling; when the safe-rate limit is needed it is worked out by the 36-step
//   bit-serial divider (one quotient bit per cycle).
// Reset: rst_n clears the detector phase, heat, quiet count, controller and
//   loads register defaults; no clearing pass.
// Stalls: one result beat waits in the output register while the next tick is
//   accepted and worked; it holds in the last step until the output is taken.
module shot_heat_budget_limiter #(
    parameter int HEAT_WIDTH = shbl_pkg::HEAT_WIDTH_DEF,
    parameter int RATE_WIDTH = shbl_pkg::RATE_WIDTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // [15:0] friction_ma, [30:16] wheel_speed, [45:31] target_speed,
    // [62:46] desired_rate, [78:63] rate_cap, [79] zero
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [shbl_pkg::S_DATA_W-1:0]  s_tdata,
    // [23:0] heat_level, [39:24] allowed_rate, [40] shot_counted,
    // [42:41] detect_phase, [47:43] zero
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [shbl_pkg::M_DATA_W-1:0]  m_tdata,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [shbl_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [shbl_pkg::CFG_DAT_W-1:0] cfg_data
);
    import shbl_pkg::*;

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    dp_cmd_t  cmd;
    dp_stat_t stat;

    // Register file: always ready; unknown indexes drop the beat
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_HEAT_MAX:      cfg_next.heat_max          = cfg_data;
                CFG_HEAT_PER_SHOT: cfg_next.heat_per_shot     = cfg_data;
                CFG_COOLING_RATE:  cfg_next.cooling_rate      = cfg_data;
                CFG_COOL_PER_TICK: cfg_next.cool_per_tick     = cfg_data[CPT_W-1:0];
                CFG_CUR_THRESH:    cfg_next.current_threshold = cfg_data[CUR_W-1:0];
                CFG_QUIET_TICKS:   cfg_next.quiet_ticks       = cfg_data[QT_W-1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.heat_max          <= HEAT_MAX_RST;
            cfg_reg.heat_per_shot     <= HEAT_PER_SHOT_RST;
            cfg_reg.cooling_rate      <= COOLING_RATE_RST;
            cfg_reg.cool_per_tick     <= COOL_PER_TICK_RST;
            cfg_reg.current_threshold <= CUR_THRESH_RST;
            cfg_reg.quiet_ticks       <= QUIET_TICKS_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Sequencer: accept, update detector, cool, test ceiling, divide, present
    shbl_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // Detector, heat bucket, rate clamp and divider
    shbl_dp #(
        .HEAT_WIDTH(HEAT_WIDTH),
        .RATE_WIDTH(RATE_WIDTH)
    ) u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_reg),
        .cmd    (cmd),
        .stat   (stat),
        .s_tdata(s_tdata),
        .m_tdata(m_tdata)
    );

endmodule

### rtl/shbl_div.sv
`include "shot_heat_budget_limiter_defines.svh"

module shbl_div #(
    parameter int NW = shbl_pkg::DVD_W,
    parameter int DW = shbl_pkg::DEN_W
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [NW-1:0] dividend,
    input  logic [DW-1:0] divisor,
    output logic [NW-1:0] quotient,
    output logic          done
);
    localparam int CNT_W = $clog2(NW);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(NW - 1);

    logic [NW-1:0]    quo_reg, quo_next;
    logic [DW-1:0]    rem_reg, rem_next;
    logic [DW-1:0]    den_reg, den_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DW:0]      rem_sh;
    logic [DW:0]      rem_sub;
    logic             ge;

    // One quotient bit per cycle, restoring form
    always_comb
    begin
        rem_sh  = {rem_reg, quo_reg[NW-1]};
        rem_sub = rem_sh - {1'b0, den_reg};
        ge      = (rem_sh >= {1'b0, den_reg});

        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            den_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[NW-2:0], ge};
            rem_next = ge ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

    `SHBL_ASSERT_IMP(a_done_idle, done_reg, !busy_reg, "divider done while busy")
    `SHBL_ASSERT_NXT(a_start_busy, start, busy_reg && (cnt_reg == '0), "divider did not start")
    `SHBL_ASSERT_NXT(a_last_done, busy_reg && !start && (cnt_reg == LAST), done_reg,
                     "divider missed done")

endmodule

### rtl/shbl_dp.sv
module shbl_dp #(
    parameter int HEAT_WIDTH = shbl_pkg::HEAT_WIDTH_DEF,
    parameter int RATE_WIDTH = shbl_pkg::RATE_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  shbl_pkg::cfg_t                cfg,
    input  shbl_pkg::dp_cmd_t             cmd,
    output shbl_pkg::dp_stat_t            stat,
    input  logic [shbl_pkg::S_DATA_W-1:0] s_tdata,
    output logic [shbl_pkg::M_DATA_W-1:0] m_tdata
);
    import shbl_pkg::*;

    localparam int HCW = ((HEAT_WIDTH > HEAT_W) ? HEAT_WIDTH : HEAT_W) + 1;
    localparam int RCW = ((RATE_WIDTH > RATE_W) ? RATE_WIDTH : RATE_W) + 1;
    localparam logic [HCW-1:0] HEAT_LIMIT = HCW'((64'd1 << HEAT_WIDTH) - 64'd1);
    localparam logic [RCW-1:0] RATE_LIMIT = RCW'((64'd1 << RATE_WIDTH) - 64'd1);

    // Input beat
    logic signed [CUR_W-1:0] cur_reg;
    logic signed [SPD_W-1:0] spd_reg;
    logic signed [SPD_W-1:0] tgt_reg;
    logic signed [DES_W-1:0] des_reg;
    logic [CAP_W-1:0]        cap_reg;

    // Detector and heat state
    phase_t                  phase_reg, phase_next;
    logic [QT_W-1:0]         qc_reg, qc_next;
    logic [HEAT_WIDTH-1:0]   heat_reg, heat_next;
    logic                    shot_reg, shot_next;

    // Rate path
    logic [RATE_W-1:0]       r_reg, r_next;
    logic [PROD_W-1:0]       prod_reg;
    logic                    near_reg;
    logic [HEAT_W-1:0]       diff_reg;
    logic [RATE_W-1:0]       rate_reg, rate_next;

    // Output beat
    logic [HEAT_W-1:0]       o_heat_reg;
    logic [RATE_W-1:0]       o_rate_reg;
    logic                    o_shot_reg;
    phase_t                  o_phase_reg;

    logic signed [SPD_W+4:0] spd10, tgt9;
    logic                    quiet;
    logic [QT_W-1:0]         qc_inc;
    logic [HCW-1:0]          heat_ext, sum, cooled;
    logic [HCW-1:0]          near_sum, diff_full;
    logic [NUM_W-1:0]        num;
    logic [DVD_W-1:0]        quo;
    logic [RCW-1:0]          rate_ext;
    logic [RATE_W-1:0]       rate_sat;
    logic                    need_div;
    logic                    div_done;

    assign heat_ext = HCW'(heat_reg);

    // Detector step and shot heat
    always_comb
    begin
        spd10  = (SPD_W+5)'(spd_reg) * 20'sd10;
        tgt9   = (SPD_W+5)'(tgt_reg) * 20'sd9;
        quiet  = (cur_reg < cfg.current_threshold);
        qc_inc = (qc_reg != COUNT_MAX) ? qc_reg + 1'b1 : qc_reg;
        sum    = heat_ext + HCW'(cfg.heat_per_shot);
        if (sum > HCW'(cfg.heat_max))
        begin
            sum = HCW'(cfg.heat_max);
        end
        if (sum > HEAT_LIMIT)
        begin
            sum = HEAT_LIMIT;
        end

        phase_next = phase_reg;
        qc_next    = qc_reg;
        heat_next  = heat_reg;
        shot_next  = 1'b0;
        case (phase_reg)
            PH_STOPPED:
            begin
                if (spd10 > tgt9)
                begin
                    phase_next = PH_PRECHECK;
                    qc_next    = '0;
                end
            end
            PH_PRECHECK:
            begin
                if (!quiet)
                begin
                    phase_next = PH_SUSPECT;
                    qc_next    = '0;
                end
            end
            PH_SUSPECT:
            begin
                if (quiet)
                begin
                    qc_next = qc_inc;
                    if (qc_inc > cfg.quiet_ticks)
                    begin
                        phase_next = PH_CONFIRM;
                        qc_next    = '0;
                    end
                end
                else
                begin
                    qc_next = '0;
                end
            end
            PH_CONFIRM:
            begin
                heat_next  = sum[HEAT_WIDTH-1:0];
                phase_next = PH_PRECHECK;
                qc_next    = '0;
                shot_next  = 1'b1;
            end
            default:
            begin
                phase_next = PH_STOPPED;
            end
        endcase

        // Desired rate clamped to [0, rate_cap]
        if (des_reg[DES_W-1])
        begin
            r_next = '0;
        end
        else if (des_reg[RATE_W-1:0] > cap_reg)
        begin
            r_next = cap_reg;
        end
        else
        begin
            r_next = des_reg[RATE_W-1:0];
        end
    end

    always_comb
    begin
        cooled    = (heat_ext > HCW'(cfg.cool_per_tick)) ?
                    heat_ext - HCW'(cfg.cool_per_tick) : '0;
        near_sum  = heat_ext + HCW'(NEAR_CEIL);
        diff_full = HCW'(cfg.heat_max) - heat_ext;
        num       = NUM_W'({diff_reg, 3'b000}) + NUM_W'({diff_reg, 1'b0})
                    + NUM_W'(cfg.cooling_rate);
        need_div  = !near_reg && (prod_reg > {cfg.cooling_rate, 8'h00});

        rate_next = rate_reg;
        if (cmd.chk)
        begin
            rate_next = near_reg ? '0 : r_reg;
        end
        else if (cmd.fin)
        begin
            if (quo < DVD_W'(r_reg))
            begin
                rate_next = quo[RATE_W-1:0];
            end
        end

        rate_ext = RCW'(rate_reg);
        rate_sat = (rate_ext > RATE_LIMIT) ? RATE_LIMIT[RATE_W-1:0] : rate_reg;
    end

    assign stat = '{need_div: need_div, div_done: div_done};

    shbl_div #(
        .NW(DVD_W),
        .DW(DEN_W)
    ) u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cmd.div_start),
        .dividend({num, 8'h00}),
        .divisor (cfg.heat_per_shot),
        .quotient(quo),
        .done    (div_done)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_STOPPED;
            qc_reg    <= '0;
            heat_reg  <= '0;
        end
        else if (cmd.upd)
        begin
            phase_reg <= phase_next;
            qc_reg    <= qc_next;
            heat_reg  <= heat_next;
        end
        else if (cmd.cool)
        begin
            heat_reg <= cooled[HEAT_WIDTH-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            cur_reg <= s_tdata[15:0];
            spd_reg <= s_tdata[30:16];
            tgt_reg <= s_tdata[45:31];
            des_reg <= s_tdata[62:46];
            cap_reg <= s_tdata[78:63];
        end
        if (cmd.upd)
        begin
            shot_reg <= shot_next;
            r_reg    <= r_next;
        end
        if (cmd.cool)
        begin
            prod_reg <= cfg.heat_per_shot * r_reg;
        end
        if (cmd.near)
        begin
            near_reg <= (near_sum >= HCW'(cfg.heat_max));
            diff_reg <= diff_full[HEAT_W-1:0];
        end
        rate_reg <= rate_next;
        if (cmd.load_out)
        begin
            o_heat_reg  <= heat_ext[HEAT_W-1:0];
            o_rate_reg  <= rate_sat;
            o_shot_reg  <= shot_reg;
            o_phase_reg <= phase_reg;
        end
    end

    assign m_tdata = {5'b00000, o_phase_reg, o_shot_reg, o_rate_reg, o_heat_reg};

endmodule

### rtl/shbl_ctrl.sv
`include "shot_heat_budget_limiter_defines.svh"

module shbl_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    output logic               m_tvalid,
    input  logic               m_tready,
    input  shbl_pkg::dp_stat_t stat,
    output shbl_pkg::dp_cmd_t  cmd
);
    import shbl_pkg::*;

    state_t state_reg, state_next;
    logic   m_tvalid_reg, m_tvalid_next;
    logic   out_free;

    assign out_free = !m_tvalid_reg || m_tready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (s_tvalid) state_next = ST_UPD;
            ST_UPD:  state_next = ST_COOL;
            ST_COOL: state_next = ST_NEAR;
            ST_NEAR: state_next = ST_CHK;
            ST_CHK:  state_next = stat.need_div ? ST_DIV : ST_OUT;
            ST_DIV:  if (stat.div_done) state_next = ST_FIN;
            ST_FIN:  state_next = ST_OUT;
            ST_OUT:  if (out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        s_tready  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready    = 1'b1;
                cmd.load_in = s_tvalid;
            end
            ST_UPD:  cmd.upd  = 1'b1;
            ST_COOL: cmd.cool = 1'b1;
            ST_NEAR: cmd.near = 1'b1;
            ST_CHK:
            begin
                cmd.chk       = 1'b1;
                cmd.div_start = stat.need_div;
            end
            ST_FIN:  cmd.fin      = 1'b1;
            ST_OUT:  cmd.load_out = out_free;
            default: cmd = '0;
        endcase

        m_tvalid_next = m_tvalid_reg;
        if (cmd.load_out)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;

    `SHBL_ASSERT_NXT(a_accept_upd, s_tvalid && s_tready, state_reg == ST_UPD,
                     "accepted beat not taken into update")
    `SHBL_ASSERT_NXT(a_out_valid, (state_reg == ST_OUT) && out_free, m_tvalid_reg,
                     "result beat not presented")
    `SHBL_ASSERT_NXT(a_div_wait, (state_reg == ST_DIV) && !stat.div_done,
                     state_reg == ST_DIV, "left divide before done")

endmodule

### sim/heat_budget_checker.sv
module heat_budget_checker
    import shbl_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [S_DATA_W-1:0]  s_tdata,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [M_DATA_W-1:0]  m_tdata,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data,
    output int                   mismatches,
    output int                   pending,
    output int                   ticks_checked,
    output int                   shots_checked,
    output int                   zero_rate_ticks
);

    typedef struct packed {
        logic [HEAT_W-1:0] heat;
        logic [RATE_W-1:0] rate;
        logic              shot;
        phase_t            phase;
    } tick_report_t;

    // Predictor state, updated with blocking assignments inside the watch block only
    cfg_t              regs;
    phase_t            det_phase;
    logic [HEAT_W-1:0] heat;
    logic [QT_W-1:0]   quiet_count;
    tick_report_t      reports_due[$];
    tick_report_t      due;
    tick_report_t      got;
    int                err_count;
    int                tick_count;
    int                shot_count;
    int                zero_count;

    function automatic logic [RATE_W-1:0] budget_rate(input logic signed [DES_W-1:0] desired,
                                                      input logic [CAP_W-1:0] cap);
        logic [63:0] r;
        logic [63:0] lim;
        logic [63:0] num;
        if (64'(heat) + 64'd65 >= 64'(regs.heat_max))
            return '0;
        r = (desired < 0) ? 64'd0 : 64'(desired);
        if (r > 64'(cap))
            r = 64'(cap);
        // sustainable rate passes untouched
        if (64'(regs.heat_per_shot) * r <= (64'(regs.cooling_rate) << 8))
            return r[RATE_W-1:0];
        num = 64'd10 * (64'(regs.heat_max) - 64'(heat)) + 64'(regs.cooling_rate);
        lim = (regs.heat_per_shot != '0) ? (num << 8) / 64'(regs.heat_per_shot) : 64'd0;
        if (r > lim)
            r = lim;
        if (r > 64'hFFFF)
            r = 64'hFFFF;
        return r[RATE_W-1:0];
    endfunction

    function automatic tick_report_t predict_tick(input logic [S_DATA_W-1:0] beat);
        logic signed [CUR_W-1:0] cur;
        logic signed [SPD_W-1:0] spd;
        logic signed [SPD_W-1:0] tgt;
        logic signed [DES_W-1:0] des;
        logic [CAP_W-1:0]        cap;
        logic [HEAT_W:0]         sum;
        tick_report_t            rep;
        cur = beat[15:0];
        spd = beat[30:16];
        tgt = beat[45:31];
        des = beat[62:46];
        cap = beat[78:63];
        rep.shot = 1'b0;
        case (det_phase)
            PH_STOPPED:
            begin
                if (10 * int'(spd) > 9 * int'(tgt))
                begin
                    det_phase = PH_PRECHECK;
                    quiet_count = '0;
                end
            end
            PH_PRECHECK:
            begin
                if (cur >= $signed(regs.current_threshold))
                begin
                    det_phase = PH_SUSPECT;
                    quiet_count = '0;
                end
            end
            PH_SUSPECT:
            begin
                if (cur < $signed(regs.current_threshold))
                begin
                    if (quiet_count != COUNT_MAX)
                        quiet_count = quiet_count + 1'b1;
                    if (quiet_count > regs.quiet_ticks)
                    begin
                        det_phase = PH_CONFIRM;
                        quiet_count = '0;
                    end
                end
                else
                begin
                    quiet_count = '0;
                end
            end
            default:
            begin
                sum = {1'b0, heat} + {1'b0, regs.heat_per_shot};
                if (sum > {1'b0, regs.heat_max})
                    sum = {1'b0, regs.heat_max};
                heat = sum[HEAT_W-1:0];
                det_phase = PH_PRECHECK;
                quiet_count = '0;
                rep.shot = 1'b1;
            end
        endcase
        if (heat > HEAT_W'(regs.cool_per_tick))
            heat = heat - HEAT_W'(regs.cool_per_tick);
        else
            heat = '0;
        rep.heat = heat;
        rep.rate = budget_rate(des, cap);
        rep.phase = det_phase;
        return rep;
    endfunction

    task automatic check_field(input string what, input longint want, input longint seen);
        if (want != seen)
        begin
            err_count++;
            $display("%0t: %s expected %0d actual %0d", $time, what, want, seen);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs.heat_max = HEAT_MAX_RST;
            regs.heat_per_shot = HEAT_PER_SHOT_RST;
            regs.cooling_rate = COOLING_RATE_RST;
            regs.cool_per_tick = COOL_PER_TICK_RST;
            regs.current_threshold = CUR_THRESH_RST;
            regs.quiet_ticks = QUIET_TICKS_RST;
            det_phase = PH_STOPPED;
            heat = '0;
            quiet_count = '0;
            reports_due.delete();
            err_count = 0;
            tick_count = 0;
            shot_count = 0;
            zero_count = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_idx_t'(cfg_index))
                    CFG_HEAT_MAX:      regs.heat_max = cfg_data;
                    CFG_HEAT_PER_SHOT: regs.heat_per_shot = cfg_data;
                    CFG_COOLING_RATE:  regs.cooling_rate = cfg_data;
                    CFG_COOL_PER_TICK: regs.cool_per_tick = cfg_data[CPT_W-1:0];
                    CFG_CUR_THRESH:    regs.current_threshold = cfg_data[CUR_W-1:0];
                    CFG_QUIET_TICKS:   regs.quiet_ticks = cfg_data[QT_W-1:0];
                    default:           ;
                endcase
            end
            // retire the oldest report before queuing the tick taken at this edge
            if (m_tvalid && m_tready)
            begin
                if (reports_due.size() == 0)
                begin
                    err_count++;
                    $display("%0t: result beat %h with no tick outstanding", $time, m_tdata);
                end
                else
                begin
                    due = reports_due.pop_front();
                    got.heat = m_tdata[23:0];
                    got.rate = m_tdata[39:24];
                    got.shot = m_tdata[40];
                    got.phase = phase_t'(m_tdata[42:41]);
                    check_field("heat_level", due.heat, got.heat);
                    check_field("allowed_rate", due.rate, got.rate);
                    check_field("shot_counted", due.shot, got.shot);
                    check_field("detect_phase", due.phase, got.phase);
                    tick_count++;
                    if (due.shot)
                        shot_count++;
                    if (due.rate == '0)
                        zero_count++;
                end
            end
            if (s_tvalid && s_tready)
                reports_due.push_back(predict_tick(s_tdata));
        end
        mismatches <= err_count;
        pending <= reports_due.size();
        ticks_checked <= tick_count;
        shots_checked <= shot_count;
        zero_rate_ticks <= zero_count;
    end

endmodule

### sim/shot_heat_budget_limiter_tb.sv
module shot_heat_budget_limiter_tb;
    import shbl_pkg::*;

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_DATA_W-1:0]  s_tdata;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_DATA_W-1:0]  m_tdata;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DAT_W-1:0] cfg_data;

    int mismatches;
    int pending;
    int ticks_checked;
    int shots_checked;
    int zero_rate_ticks;

    // Stimulus bookkeeping: beats sent, current idle odds, and a shadow of the
    // detector settings so shot sequences can be shaped around them
    int ticks_sent;
    int tx_gap_pct;
    int rx_stall_pct;
    int thr_now;
    int quiet_now;

    shot_heat_budget_limiter dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    heat_budget_checker checker_inst (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .mismatches      (mismatches),
        .pending         (pending),
        .ticks_checked   (ticks_checked),
        .shots_checked   (shots_checked),
        .zero_rate_ticks (zero_rate_ticks)
    );

    always #5 clk = ~clk;

    // Stall the result side at random; the odds follow the current idle profile
    always @(posedge clk)
    begin
        if (rst_n)
            m_tready <= ($urandom_range(99) >= rx_stall_pct);
    end

    function automatic int pick(input int lo, input int hi);
        return lo + int'($urandom_range(hi - lo));
    endfunction

    // tdata layout: cur [15:0], speed [30:16], target [45:31], desired [62:46],
    // cap [78:63], zero pad [79]
    function automatic logic [S_DATA_W-1:0] pack_tick(input int cur, input int spd,
                                                      input int tgt, input int des,
                                                      input int cap);
        return {1'b0, 16'(cap), 17'(des), 15'(tgt), 15'(spd), 16'(cur)};
    endfunction

    // Drive one tick beat and hold it until the block takes it. Valid stays high
    // on return so back-to-back beats never drop it within a step.
    task automatic send_beat(input logic [S_DATA_W-1:0] beat);
        // Sender idles 35%, receiver 48%; then swap; then run flat out
        if (ticks_sent < 640)
        begin
            tx_gap_pct = 35;
            rx_stall_pct = 48;
        end
        else if (ticks_sent < 1280)
        begin
            tx_gap_pct = 48;
            rx_stall_pct = 35;
        end
        else
        begin
            tx_gap_pct = 0;
            rx_stall_pct = 0;
        end
        while ($urandom_range(99) < tx_gap_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= beat;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        ticks_sent++;
    endtask

    // Send a tick with the given wheel current and random speeds and rates.
    // Rates lean toward small values so both the sustainable and the
    // budget-limited paths come up often.
    task automatic send_tick(input int cur);
        int des;
        int cap;
        case ($urandom_range(3))
            0:       des = pick(-65536, 65535);
            1:       des = pick(0, 600);
            2:       des = pick(0, 6000);
            default: des = 65535;
        endcase
        case ($urandom_range(3))
            0:       cap = 65535;
            1:       cap = pick(0, 1000);
            default: cap = pick(0, 65535);
        endcase
        send_beat(pack_tick(cur, pick(-16384, 16383), pick(-16384, 16383), des, cap));
    endtask

    function automatic int spike_current();
        return pick(thr_now, 20000);
    endfunction

    function automatic int quiet_current();
        return (thr_now > -20000) ? pick(-20000, thr_now - 1) : -20000;
    endfunction

    // Hold off the sender until every tick taken has come back
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    // Write one register; valid is left high so a burst of writes stays continuous
    task automatic write_reg(input cfg_idx_t idx, input int val);
        cfg_index <= idx;
        cfg_data <= 24'(val);
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    task automatic configure(input int hmax, input int hps, input int crate, input int cpt,
                             input int thr, input int qt);
        drain();
        write_reg(CFG_HEAT_MAX, hmax);
        write_reg(CFG_HEAT_PER_SHOT, hps);
        write_reg(CFG_COOLING_RATE, crate);
        write_reg(CFG_COOL_PER_TICK, cpt);
        write_reg(CFG_CUR_THRESH, thr);
        write_reg(CFG_QUIET_TICKS, qt);
        cfg_valid <= 1'b0;
        thr_now = thr;
        quiet_now = qt;
    endtask

    // Spike, then enough quiet ticks to confirm (at most 40), then the tick that books the shot.
    // A broken sequence cuts the quiet run short and spikes again.
    task automatic shot_sequence(input bit broken);
        int n_quiet;
        repeat (pick(1, 3))
            send_tick(spike_current());
        n_quiet = (quiet_now < 40) ? quiet_now + 1 : 40;
        if (broken)
            n_quiet = pick(0, n_quiet);
        repeat (n_quiet)
            send_tick(quiet_current());
        if (broken)
            send_tick(spike_current());
        else
            send_tick(pick(-20000, 20000));
    endtask

    task automatic run_phase(input int hmax, input int hps, input int crate, input int cpt,
                             input int thr, input int qt, input int n_ticks);
        int stop_at;
        int kind;
        configure(hmax, hps, crate, cpt, thr, qt);
        stop_at = ticks_sent + n_ticks;
        while (ticks_sent < stop_at)
        begin
            kind = $urandom_range(9);
            if (kind == 0)
                send_tick(pick(-20000, 20000));
            else
                shot_sequence(kind == 1);
            // now and then pause until the block has emptied
            if ($urandom_range(49) == 0)
                drain();
        end
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_HEAT_MAX;
        cfg_data = '0;
        thr_now = 1400;
        quiet_now = 20;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed ticks on reset settings: speed test edges while stopped
        // (equal products stay stopped), rate extremes, threshold equality
        send_beat(pack_tick(0, 9, 10, -65536, 65535));
        send_beat(pack_tick(0, -16384, 16383, 65535, 0));
        send_beat(pack_tick(0, 0, 0, 0, 0));
        send_beat(pack_tick(0, 16383, -16384, 65535, 65535));
        // sustainable boundary at default shot heat and cooling: 358 passes, 359 needs the divider
        send_beat(pack_tick(1399, 0, 0, 358, 65535));
        send_beat(pack_tick(-20000, 0, 0, 359, 65535));
        send_beat(pack_tick(1400, 0, 0, 1000, 2000));
        send_beat(pack_tick(1399, 0, 0, 1000, 2000));
        // spike in suspect clears the quiet count
        send_beat(pack_tick(20000, 0, 0, 65535, 65535));
        // shorten the quiet window so confirmations fit in a few ticks
        drain();
        write_reg(CFG_QUIET_TICKS, 1);
        cfg_valid <= 1'b0;
        quiet_now = 1;
        send_beat(pack_tick(1399, 0, 0, 500, 65535));
        send_beat(pack_tick(-20000, 0, 0, 500, 65535));
        send_beat(pack_tick(0, 0, 0, 500, 65535));
        send_beat(pack_tick(20000, 0, 0, -1, 65535));
        send_beat(pack_tick(-1, 0, 0, 65535, 65535));
        send_beat(pack_tick(-20000, 0, 0, 65535, 65535));
        send_beat(pack_tick(1400, 0, 0, 65535, 65535));

        // Random sequences across register settings, extremes included:
        // fast heat-up to the ceiling, full-scale values with no cooling,
        // zero ceiling, zero shot heat with a window that never confirms,
        // heavy cooling, reset-like values, minimum step sizes, then defaults
        run_phase(15073280, 3000000, 917504, 918, 1400, 3, 300);
        run_phase(16777215, 16777215, 0, 0, 20000, 0, 250);
        run_phase(0, 655360, 16777215, 65535, -20000, 1, 150);
        run_phase(8000000, 0, 100, 300, -500, 4095, 200);
        run_phase(5000000, 40000, 2000000, 65535, 0, 2, 300);
        run_phase(12000000, 655360, 917504, 918, 1400, 20, 300);
        run_phase(16777215, 1, 16777215, 1, -19999, 1, 200);
        run_phase(int'(HEAT_MAX_RST), int'(HEAT_PER_SHOT_RST), int'(COOLING_RATE_RST),
                  int'(COOL_PER_TICK_RST), int'(CUR_THRESH_RST), int'(QUIET_TICKS_RST), 250);

        // Wait out the last results, then allow one divider run for strays
        drain();
        repeat (60) @(posedge clk);

        $display("Checked %0d ticks over eight register settings, %0d shots booked",
                 ticks_checked, shots_checked);
        $display("%0d ticks gave a zero allowed rate", zero_rate_ticks);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Hard stop well past the slowest legal run
    initial
    begin
        #10000000;
        $display("FAILURE");
        $finish;
    end

endmodule
